@@ rtl/core/tmp_pkg.sv @@
// ----------------------------------------------------------------------------
// tmp_pkg: shared types and codes of the trapezoidal motion profile core
// Beat payloads, register indexes, phase and action codes, and the command
// group that drives the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package tmp_pkg;

    typedef struct packed {
        logic               action;
        logic signed [31:0] target_distance;
        logic signed [31:0] sample_time;
    } t_in_item;

    typedef struct packed {
        logic               plan_ok;
        logic signed [31:0] position;
        logic [30:0]        velocity;
        logic signed [31:0] acceleration;
        logic [1:0]         phase_code;
        logic               move_done;
    } t_out_item;

    localparam logic ACT_PLAN   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [1:0] REG_MAX_VELOCITY     = 2'd0;
    localparam logic [1:0] REG_MAX_ACCELERATION = 2'd1;
    localparam logic [1:0] REG_MAX_JERK         = 2'd2;

    localparam logic [1:0] PH_NONE       = 2'd0;
    localparam logic [1:0] PH_ACCELERATE = 2'd1;
    localparam logic [1:0] PH_CRUISE     = 2'd2;
    localparam logic [1:0] PH_DECELERATE = 2'd3;

    // product only, product shifted down by the fraction bits, product / divisor
    typedef enum logic [1:0] {
        MD_MUL = 2'd0,
        MD_SHR = 2'd1,
        MD_DIV = 2'd2
    } t_md_mode;

    typedef struct packed {
        logic     start;
        t_md_mode mode;
        logic     shr_extra;
    } t_md_ctrl;

endpackage

@@ rtl/core/tmp_muldiv.sv @@
// ----------------------------------------------------------------------------
// tmp_muldiv: bit-serial multiply, then shift or divide
// Forms x*y one multiplier bit per cycle, then either shifts the product by
// FRAC_BITS (or one more), or runs a restoring divide one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tmp_muldiv #(
    parameter int DW        = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmp_pkg::t_md_ctrl  i_ctrl,
    input  logic [DW-1:0]      i_x,
    input  logic [DW-1:0]      i_y,
    input  logic [DW-1:0]      i_z,
    output logic               o_done,
    output logic [2*DW-1:0]    o_q
);

    localparam int PW = 2 * DW;
    localparam int CW = $clog2(PW + 1);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } t_md_state;

    t_md_state         r_state;
    tmp_pkg::t_md_mode r_mode;
    logic              r_shr_extra;
    logic [CW-1:0]     r_cnt;
    logic [DW-1:0]     r_x;
    logic [DW-1:0]     r_z;
    logic [PW-1:0]     r_p;
    logic [DW-1:0]     r_rem;
    logic              r_done;

    logic [DW:0]       w_sum;
    logic [PW-1:0]     w_mul_next;
    logic [DW:0]       w_trial;
    logic              w_ge;
    logic [DW:0]       w_diff;

    always_comb begin
        w_sum      = {1'b0, r_p[PW-1:DW]} + (r_p[0] ? {1'b0, r_x} : {(DW+1){1'b0}});
        w_mul_next = {w_sum, r_p[DW-1:1]};
        w_trial    = {r_rem, r_p[PW-1]};
        w_ge       = (w_trial >= {1'b0, r_z});
        w_diff     = w_trial - {1'b0, r_z};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_ctrl.start) begin
                        r_x         <= i_x;
                        r_z         <= i_z;
                        r_p         <= {{DW{1'b0}}, i_y};
                        r_mode      <= i_ctrl.mode;
                        r_shr_extra <= i_ctrl.shr_extra;
                        r_cnt       <= CW'(DW);
                        r_state     <= U_MUL;
                    end
                end
                U_MUL: begin
                    r_cnt <= r_cnt - 1'b1;
                    r_p   <= w_mul_next;
                    if (r_cnt == CW'(1)) begin
                        case (r_mode)
                            tmp_pkg::MD_SHR: begin
                                r_p     <= r_shr_extra ? (w_mul_next >> (FRAC_BITS + 1))
                                                       : (w_mul_next >> FRAC_BITS);
                                r_done  <= 1'b1;
                                r_state <= U_IDLE;
                            end
                            tmp_pkg::MD_DIV: begin
                                r_rem   <= '0;
                                r_cnt   <= CW'(PW);
                                r_state <= U_DIV;
                            end
                            default: begin
                                r_done  <= 1'b1;
                                r_state <= U_IDLE;
                            end
                        endcase
                    end
                end
                U_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                    r_p   <= {r_p[PW-2:0], w_ge};
                    if (r_cnt == CW'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_p;

endmodule

@@ rtl/core/trapezoidal_motion_profile_core.sv @@
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile_core: symmetric trapezoidal move planner/sampler
// Plans a move from the limit registers and a distance, then evaluates
// position, velocity, acceleration and phase at sample times.
// ----------------------------------------------------------------------------
// One item at a time. Every product and quotient goes through one shared
// bit-serial unit on DW-bit operands, DW being the larger of WORD_BITS and 32.
// A long-move plan takes two quotients and a scaled product. A short-move plan
// skips the cruise quotient but adds a product, a square root and a second
// quotient and product, and is the slowest item. A sample in the decelerate
// phase takes one or two quotients and three scaled products.
// The next item is taken as soon as its result sits in the output register.
module trapezoidal_motion_profile_core #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tmp_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tmp_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int DW = (WORD_BITS > 32) ? WORD_BITS : 32;
    localparam int PW = 2 * DW;
    localparam logic [DW-1:0] WMAX    = DW'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [DW-1:0] ONE_Q   = DW'(64'd1 << FRAC_BITS);
    localparam logic [DW+1:0] POS_MAX = (DW+2)'(32'h7fff_ffff);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RUN  = 5'b00010,
        ST_WAIT = 5'b00100,
        ST_SQRT = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    typedef enum logic [4:0] {
        PL_T1, PL_SA, PL_R, PL_TC, PL_AD, PL_FIN1, PL_FIN2,
        SM_CLAMP, SM_SEL, SM_A1, SM_A2, SM_C1,
        SM_D0, SM_D1, SM_D2, SM_D3, SM_D4, SM_D5, SM_D6
    } t_step;

    function automatic logic [DW-1:0] f_sat_p(input logic [PW-1:0] q);
        f_sat_p = (q > PW'(WMAX)) ? WMAX : q[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] f_sat_s(input logic [DW:0] s);
        f_sat_s = (s > (DW+1)'(WMAX)) ? WMAX : s[DW-1:0];
    endfunction

    t_state             r_state;
    t_step              r_step;
    tmp_pkg::t_in_item  r_item;
    logic [30:0]        r_max_vel;
    logic [30:0]        r_max_acc;
    logic [30:0]        r_max_jerk;
    logic               r_plan_valid;
    logic [DW-1:0]      r_t1;
    logic [DW-1:0]      r_t2;
    logic [DW-1:0]      r_t3;
    logic [DW-1:0]      r_pk;
    logic [DW-1:0]      r_sa;
    logic [30:0]        r_pacc;
    logic               r_short;
    logic [DW-1:0]      r_ta;
    logic [DW-1:0]      r_td;
    logic [DW-1:0]      r_span;
    logic [DW-1:0]      r_t;
    logic [DW-1:0]      r_tmp;
    logic [DW-1:0]      r_gain;
    logic [PW-1:0]      r_sq_x;
    logic [PW-1:0]      r_sq_r;
    logic [PW-1:0]      r_sq_b;
    logic               r_ok;
    logic [DW+1:0]      r_pos;
    logic [DW-1:0]      r_vel;
    logic [31:0]        r_acc;
    logic [1:0]         r_phase;
    logic               r_done;
    logic               r_out_valid;
    tmp_pkg::t_out_item r_out;

    tmp_pkg::t_md_ctrl  w_md_ctrl;
    logic [DW-1:0]      w_md_x;
    logic [DW-1:0]      w_md_y;
    logic [DW-1:0]      w_md_z;
    logic               w_md_done;
    logic [PW-1:0]      w_md_q;
    logic [DW-1:0]      w_q_sat;

    logic [DW-1:0]      w_vel_cap;
    logic [DW-1:0]      w_acc_cap;
    logic [DW-1:0]      w_dist;
    logic signed [DW+1:0] w_rem;
    logic               w_rem_pos;
    logic [DW-1:0]      w_tnn;
    logic [PW-1:0]      w_sq_sum;
    logic               w_sq_ge;
    logic               w_in_fire;
    logic               w_out_free;
    logic               w_plan_good;

    assign w_vel_cap = DW'(r_max_vel);
    assign w_acc_cap = DW'(r_max_acc);
    assign w_dist    = DW'(r_item.target_distance[31:0]);
    assign w_rem     = $signed({2'b00, w_dist}) - $signed({1'b0, r_sa, 1'b0});
    assign w_rem_pos = !w_rem[DW+1] && (w_rem != '0);
    assign w_tnn     = r_item.sample_time[31] ? '0 : DW'(r_item.sample_time[31:0]);
    assign w_sq_sum  = r_sq_r + r_sq_b;
    assign w_sq_ge   = (r_sq_x >= w_sq_sum);
    assign w_q_sat   = f_sat_p(w_md_q);
    assign w_in_fire = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_plan_good = !i_in.target_distance[31] && (i_in.target_distance != '0)
                         && (r_max_vel != '0) && (r_max_acc != '0) && (r_max_jerk != '0);

    // operand select for the shared unit
    always_comb begin
        w_md_ctrl.start     = 1'b0;
        w_md_ctrl.mode      = tmp_pkg::MD_SHR;
        w_md_ctrl.shr_extra = 1'b0;
        w_md_x = r_pk;
        w_md_y = r_td;
        w_md_z = r_span;
        if (r_state == ST_RUN) begin
            unique case (r_step)
                PL_T1: begin
                    w_md_ctrl.start = 1'b1;
                    w_md_ctrl.mode  = tmp_pkg::MD_DIV;
                    w_md_y = ONE_Q;
                    w_md_z = w_acc_cap;
                end
                PL_SA: begin
                    w_md_ctrl.start     = 1'b1;
                    w_md_ctrl.shr_extra = 1'b1;
                    w_md_y = r_t1;
                end
                PL_TC: begin
                    w_md_ctrl.start = 1'b1;
                    w_md_ctrl.mode  = tmp_pkg::MD_DIV;
                    w_md_x = r_ta;
                    w_md_y = ONE_Q;
                    w_md_z = w_vel_cap;
                end
                PL_AD: begin
                    w_md_ctrl.start = 1'b1;
                    w_md_ctrl.mode  = tmp_pkg::MD_MUL;
                    w_md_x = w_acc_cap;
                    w_md_y = w_dist;
                end
                SM_A1: begin
                    w_md_ctrl.start = 1'b1;
                    w_md_ctrl.mode  = tmp_pkg::MD_DIV;
                    w_md_y = r_t;
                    w_md_z = r_t1;
                end
                SM_A2: begin
                    w_md_ctrl.start     = 1'b1;
                    w_md_ctrl.shr_extra = 1'b1;
                    w_md_x = r_vel;
                    w_md_y = r_t;
                end
                SM_C1: begin
                    w_md_ctrl.start = 1'b1;
                    w_md_y = r_ta;
                end
                SM_D1: begin
                    w_md_ctrl.start = 1'b1;
                    w_md_ctrl.mode  = tmp_pkg::MD_DIV;
                    w_md_y = r_ta;
                end
                SM_D2: begin
                    w_md_ctrl.start = 1'b1;
                end
                SM_D3: begin
                    w_md_ctrl.start = 1'b1;
                    w_md_ctrl.mode  = tmp_pkg::MD_DIV;
                end
                SM_D4: begin
                    w_md_ctrl.start     = 1'b1;
                    w_md_ctrl.shr_extra = 1'b1;
                    w_md_x = r_tmp;
                end
                SM_D5: begin
                    w_md_ctrl.start = 1'b1;
                    w_md_y = r_t2 - r_t1;
                end
                default: begin
                    w_md_ctrl.start = 1'b0;
                end
            endcase
        end
    end

    tmp_muldiv #(
        .DW        (DW),
        .FRAC_BITS (FRAC_BITS)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_md_ctrl),
        .i_x     (w_md_x),
        .i_y     (w_md_y),
        .i_z     (w_md_z),
        .o_done  (w_md_done),
        .o_q     (w_md_q)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel  <= '0;
            r_max_acc  <= '0;
            r_max_jerk <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tmp_pkg::REG_MAX_VELOCITY:     r_max_vel  <= i_cfg_data[30:0];
                tmp_pkg::REG_MAX_ACCELERATION: r_max_acc  <= i_cfg_data[30:0];
                tmp_pkg::REG_MAX_JERK:         r_max_jerk <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= PL_T1;
            r_plan_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        r_item  <= i_in;
                        r_ok    <= 1'b0;
                        r_pos   <= '0;
                        r_vel   <= '0;
                        r_acc   <= '0;
                        r_phase <= tmp_pkg::PH_NONE;
                        r_done  <= 1'b0;
                        if (i_in.action == tmp_pkg::ACT_PLAN) begin
                            r_plan_valid <= 1'b0;
                            r_pk         <= DW'(r_max_vel);
                            r_short      <= 1'b0;
                            r_step       <= PL_T1;
                            r_state      <= w_plan_good ? ST_RUN : ST_OUT;
                        end else begin
                            r_ok    <= r_plan_valid;
                            r_step  <= SM_CLAMP;
                            r_state <= r_plan_valid ? ST_RUN : ST_OUT;
                        end
                    end
                end
                ST_RUN: begin
                    r_state <= ST_WAIT;
                    unique case (r_step)
                        PL_R: begin
                            r_state <= ST_RUN;
                            if (w_rem_pos) begin
                                r_ta   <= w_rem[DW-1:0];
                                r_step <= PL_TC;
                            end else begin
                                r_step <= PL_AD;
                            end
                        end
                        PL_FIN1: begin
                            r_t2    <= f_sat_s({1'b0, r_t1} + {1'b0, r_ta});
                            r_step  <= PL_FIN2;
                            r_state <= ST_RUN;
                        end
                        PL_FIN2: begin
                            r_t3         <= f_sat_s({1'b0, r_t2} + {1'b0, r_t1});
                            r_pacc       <= r_max_acc;
                            r_plan_valid <= 1'b1;
                            r_ok         <= 1'b1;
                            r_state      <= ST_OUT;
                        end
                        SM_CLAMP: begin
                            if (w_tnn > r_t3) begin
                                r_t    <= r_t3;
                                r_done <= 1'b1;
                            end else begin
                                r_t <= w_tnn;
                            end
                            r_step  <= SM_SEL;
                            r_state <= ST_RUN;
                        end
                        SM_SEL: begin
                            r_state <= ST_RUN;
                            if (r_t <= r_t1) begin
                                r_phase <= tmp_pkg::PH_ACCELERATE;
                                r_acc   <= {1'b0, r_pacc};
                                r_step  <= SM_A1;
                                if (r_t1 == '0) begin
                                    r_state <= ST_OUT;
                                end
                            end else if (r_t <= r_t2) begin
                                r_phase <= tmp_pkg::PH_CRUISE;
                                r_vel   <= r_pk;
                                r_ta    <= r_t - r_t1;
                                r_step  <= SM_C1;
                            end else begin
                                r_phase <= tmp_pkg::PH_DECELERATE;
                                r_acc   <= 32'd0 - {1'b0, r_pacc};
                                r_td    <= r_t - r_t2;
                                r_span  <= r_t3 - r_t2;
                                r_step  <= SM_D0;
                            end
                        end
                        SM_D0: begin
                            r_state <= ST_RUN;
                            if (r_td >= r_span) begin
                                r_vel  <= '0;
                                r_step <= SM_D2;
                            end else begin
                                r_ta   <= r_span - r_td;
                                r_step <= SM_D1;
                            end
                        end
                        SM_D5: begin
                            // gain less the clipped drop
                            r_gain <= r_gain - ((r_tmp > r_gain) ? r_gain : r_tmp);
                        end
                        SM_D6: begin
                            r_pos   <= r_pos + (DW+2)'(r_gain);
                            r_state <= ST_OUT;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_WAIT: begin
                    if (w_md_done) begin
                        r_state <= ST_RUN;
                        unique case (r_step)
                            PL_T1: begin
                                r_t1   <= w_q_sat;
                                r_step <= PL_SA;
                            end
                            PL_SA: begin
                                r_sa <= w_q_sat;
                                if (r_short) begin
                                    r_ta   <= '0;
                                    r_step <= PL_FIN1;
                                end else begin
                                    r_step <= PL_R;
                                end
                            end
                            PL_TC: begin
                                r_ta   <= w_q_sat;
                                r_step <= PL_FIN1;
                            end
                            PL_AD: begin
                                r_sq_x  <= w_md_q;
                                r_sq_r  <= '0;
                                r_sq_b  <= PW'(1) << (PW - 2);
                                r_state <= ST_SQRT;
                            end
                            SM_A1: begin
                                r_vel  <= w_q_sat;
                                r_step <= SM_A2;
                            end
                            SM_A2: begin
                                r_pos   <= (DW+2)'(w_q_sat);
                                r_state <= ST_OUT;
                            end
                            SM_C1: begin
                                r_pos   <= (DW+2)'(r_sa) + (DW+2)'(w_q_sat);
                                r_state <= ST_OUT;
                            end
                            SM_D1: begin
                                r_vel  <= w_q_sat;
                                r_step <= SM_D2;
                            end
                            SM_D2: begin
                                r_gain <= w_q_sat;
                                r_step <= SM_D3;
                            end
                            SM_D3: begin
                                r_tmp  <= w_q_sat;
                                r_step <= SM_D4;
                            end
                            SM_D4: begin
                                r_tmp  <= w_q_sat;
                                r_step <= SM_D5;
                            end
                            SM_D5: begin
                                r_pos  <= (DW+2)'(r_sa) + (DW+2)'(w_q_sat);
                                r_step <= SM_D6;
                            end
                            default: begin
                                r_state <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_SQRT: begin
                    if (r_sq_b == '0) begin
                        // short move: peak is the root, capped at the velocity limit
                        r_pk    <= (r_sq_r > PW'(r_max_vel)) ? w_vel_cap : r_sq_r[DW-1:0];
                        r_short <= 1'b1;
                        r_step  <= PL_T1;
                        r_state <= ST_RUN;
                    end else begin
                        if (w_sq_ge) begin
                            r_sq_x <= r_sq_x - w_sq_sum;
                            r_sq_r <= (r_sq_r >> 1) + r_sq_b;
                        end else begin
                            r_sq_r <= r_sq_r >> 1;
                        end
                        r_sq_b <= r_sq_b >> 2;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out.plan_ok      <= r_ok;
                        r_out.position     <= (r_pos > POS_MAX) ? 32'sh7fff_ffff
                                                                : $signed(r_pos[31:0]);
                        r_out.velocity     <= r_vel[30:0];
                        r_out.acceleration <= $signed(r_acc);
                        r_out.phase_code   <= r_phase;
                        r_out.move_done    <= r_done;
                        r_out_valid        <= 1'b1;
                        r_state            <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.phase_code == tmp_pkg::PH_NONE) |->
        (o_out.velocity == '0 && o_out.position == '0 && o_out.acceleration == '0))
        else $error("result without a phase carries motion");

    a_done_has_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.move_done) |->
        (o_out.plan_ok && o_out.phase_code != tmp_pkg::PH_NONE))
        else $error("move_done without a held plan");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !o_in_ready)
        else $error("input taken again before the beat was worked");

    a_unit_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> (r_state == ST_WAIT))
        else $error("arithmetic unit finished outside of a wait");
`endif

endmodule
